### rtl/ipv4p_pkg.sv
package ipv4p_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] LIMIT_1PART = 32'h00ff_ffff;
    localparam logic [31:0] LIMIT_2PART = 32'h0000_ffff;
    localparam logic [31:0] LIMIT_3PART = 32'h0000_00ff;

    typedef enum logic [2:0] {
        K_NUL,
        K_DIGIT,
        K_HEX,
        K_X,
        K_DOT,
        K_SPACE,
        K_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] val;
    } t_cls;

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_TRAIL,
        PH_FAIL
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

endpackage

### rtl/ipv4p_front.sv
module ipv4p_front
    import ipv4p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ch,
    output logic       o_q_valid,
    input  logic       i_q_full,
    output t_cls       o_q_cls
);

    logic r_valid;
    t_cls r_cls;
    logic ready;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r.val  = 4'd0;
        r.kind = K_OTHER;
        if (c == 8'h00) begin
            r.kind = K_NUL;
        end else if (c inside {[8'h30:8'h39]}) begin
            r.kind = K_DIGIT;
            r.val  = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r.kind = K_HEX;
            r.val  = c[3:0] + 4'd9;
        end else if (c == 8'h78 || c == 8'h58) begin
            r.kind = K_X;
        end else if (c == 8'h2e) begin
            r.kind = K_DOT;
        end else if (c == 8'h20 || c inside {[8'h09:8'h0d]}) begin
            r.kind = K_SPACE;
        end
        return r;
    endfunction

    assign ready      = !r_valid || !i_q_full;
    assign o_in_stall = !ready;
    assign o_q_valid  = r_valid;
    assign o_q_cls    = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_in_valid) begin
            r_cls <= classify(i_ch);
        end
    end

endmodule

### rtl/ipv4p_queue.sv
module ipv4p_queue
    import ipv4p_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    input  t_cls i_wr_cls,
    output logic o_full,
    output logic o_rd_valid,
    input  logic i_rd_en,
    output t_cls o_rd_cls
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_full     = r_count == CW'(DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_cls   = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && !o_full;
    assign pop        = o_rd_valid && i_rd_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_cls;
        end
    end

endmodule

### rtl/ipv4p_back.sv
module ipv4p_back
    import ipv4p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cls        i_q_cls,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [31:0] o_address
);

    t_phase      r_phase, n_phase;
    t_radix      r_radix, n_radix;
    logic [31:0] r_pv, n_pv;
    logic [1:0]  r_parts, n_parts;
    logic [31:0] r_saved [3];
    logic        r_out_valid;
    logic        r_ok;
    logic [31:0] r_addr;

    logic        save;
    t_radix      eff_radix;
    logic [31:0] mul_pv;
    logic        fin_ok;
    logic [31:0] fin_addr;
    logic        is_nul;

    assign is_nul      = i_q_cls.kind == K_NUL;
    assign o_pop       = i_q_valid && (!is_nul || !r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_address   = r_addr;

    assign eff_radix = (r_phase == PH_ZERO) ? RADIX_OCT : r_radix;

    always_comb begin
        case (eff_radix)
            RADIX_HEX: mul_pv = {r_pv[27:0], 4'd0};
            RADIX_OCT: mul_pv = {r_pv[28:0], 3'd0};
            default:   mul_pv = {r_pv[28:0], 3'd0} + {r_pv[30:0], 1'b0};
        endcase
    end

    always_comb begin
        fin_ok   = r_phase inside {PH_ZERO, PH_DIGITS, PH_TRAIL};
        fin_addr = r_pv;
        case (r_parts)
            2'd0: ;
            2'd1: begin
                if (r_pv > LIMIT_1PART) fin_ok = 1'b0;
                fin_addr = r_pv | {r_saved[0][7:0], 24'd0};
            end
            2'd2: begin
                if (r_pv > LIMIT_2PART) fin_ok = 1'b0;
                fin_addr = r_pv | {r_saved[0][7:0], 24'd0} | {r_saved[1][15:0], 16'd0};
            end
            default: begin
                if (r_pv > LIMIT_3PART) fin_ok = 1'b0;
                fin_addr = r_pv | {r_saved[0][7:0], 24'd0} | {r_saved[1][15:0], 16'd0}
                         | {r_saved[2][23:0], 8'd0};
            end
        endcase
        if (!fin_ok) fin_addr = '0;
    end

    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_pv    = r_pv;
        n_parts = r_parts;
        save    = 1'b0;
        if (is_nul) begin
            n_phase = PH_START;
            n_radix = RADIX_DEC;
            n_pv    = '0;
            n_parts = '0;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (i_q_cls.kind != K_DIGIT) begin
                        n_phase = PH_FAIL;
                    end else if (i_q_cls.val == 4'd0) begin
                        n_pv    = '0;
                        n_phase = PH_ZERO;
                    end else begin
                        n_radix = RADIX_DEC;
                        n_pv    = {28'd0, i_q_cls.val};
                        n_phase = PH_DIGITS;
                    end
                end
                PH_ZERO, PH_DIGITS: begin
                    n_phase = PH_DIGITS;
                    if (r_phase == PH_ZERO && i_q_cls.kind == K_X) begin
                        n_radix = RADIX_HEX;
                    end else begin
                        if (r_phase == PH_ZERO) n_radix = RADIX_OCT;
                        if (i_q_cls.kind == K_DIGIT) begin
                            n_pv = mul_pv + {28'd0, i_q_cls.val};
                        end else if (eff_radix == RADIX_HEX && i_q_cls.kind == K_HEX) begin
                            n_pv = {r_pv[27:0], i_q_cls.val};
                        end else if (i_q_cls.kind == K_DOT) begin
                            if (r_parts == 2'd3) begin
                                n_phase = PH_FAIL;
                            end else begin
                                save    = 1'b1;
                                n_parts = r_parts + 2'd1;
                                n_pv    = '0;
                                n_radix = RADIX_DEC;
                                n_phase = PH_START;
                            end
                        end else if (i_q_cls.kind == K_SPACE) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                end
                PH_TRAIL: ;
                default:  n_phase = PH_FAIL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_radix     <= RADIX_DEC;
            r_pv        <= '0;
            r_parts     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_pv    <= n_pv;
                r_parts <= n_parts;
            end
            if (o_pop && is_nul) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && save) begin
            r_saved[r_parts] <= r_pv;
        end
        if (o_pop && is_nul) begin
            r_ok   <= fin_ok;
            r_addr <= fin_addr;
        end
    end

endmodule

### rtl/ipv4_dotted_text_parser.sv
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_ch[7:0]
// out       output     o_out_valid/i_out_stall o_ok, o_address[31:0]
//
// One text byte per cycle while o_in_stall is low, set by the back end update.
// A NUL byte passes the front register and queue; the back end registers its result.
// Synchronous active-low reset empties the front register, queue and output.
// The front register and queue absorb a stalled output; input stalls only
// when both are full.
module ipv4_dotted_text_parser
    import ipv4p_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [31:0] o_address
);

    logic w_fq_valid;
    logic w_q_full;
    t_cls w_fq_cls;
    logic w_q_valid;
    logic w_pop;
    t_cls w_q_cls;

    ipv4p_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_ch       (i_ch),
        .o_q_valid  (w_fq_valid),
        .i_q_full   (w_q_full),
        .o_q_cls    (w_fq_cls)
    );

    ipv4p_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .i_wr_cls   (w_fq_cls),
        .o_full     (w_q_full),
        .o_rd_valid (w_q_valid),
        .i_rd_en    (w_pop),
        .o_rd_cls   (w_q_cls)
    );

    ipv4p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cls     (w_q_cls),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ok        (o_ok),
        .o_address   (o_address)
    );

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_address == 32'd0)
        else $error("failed request carries non-zero address");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_fq_valid && w_q_full)
        else $error("input stalled with room in front end");

    a_nul_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_q_cls.kind == K_NUL |=> o_out_valid)
        else $error("string end gave no result");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    import ipv4p_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam int RANDOM_BYTES   = 1870;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT    = 2000;

    typedef struct packed {
        bit          ok;
        logic [31:0] addr;
    } addr_result_t;

    typedef struct packed {
        logic [7:0]  ch;
        bit          typed;
        bit          ok;
        logic [31:0] addr;
    } dir_row_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_ch        = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_ok;
    logic [31:0] o_address;

    // parser shadow state
    t_phase      pp_phase  = PH_START;
    t_radix      pp_radix  = RADIX_DEC;
    logic [31:0] pp_value  = '0;
    logic [1:0]  pp_parts  = '0;
    logic [31:0] pp_saved [3] = '{32'h0, 32'h0, 32'h0};

    addr_result_t pending_addr_q [$];
    addr_result_t got_want;
    logic [7:0]   text_q [$];
    int           fail_cnt    = 0;
    int           sent_cnt    = 0;
    int           hold_left   = 0;
    bit           rx_hold_req = 0;
    bit           calm        = 0;

    // empty, bare hex prefix, dot at part start, fifth part,
    // octal with a 9 plus trailing blank and ignored high byte, bad trailing byte
    dir_row_t dir_rows [26] = '{
        '{CH_NUL, 1'b1, 1'b0, 32'h0},
        '{CH_0,   1'b0, 1'b0, 32'h0},
        '{CH_X_LO, 1'b0, 1'b0, 32'h0},
        '{CH_NUL, 1'b1, 1'b1, 32'h0},
        '{CH_DOT, 1'b0, 1'b0, 32'h0},
        '{CH_NUL, 1'b1, 1'b0, 32'h0},
        '{CH_0,   1'b0, 1'b0, 32'h0},
        '{CH_DOT, 1'b0, 1'b0, 32'h0},
        '{CH_0,   1'b0, 1'b0, 32'h0},
        '{CH_DOT, 1'b0, 1'b0, 32'h0},
        '{CH_0,   1'b0, 1'b0, 32'h0},
        '{CH_DOT, 1'b0, 1'b0, 32'h0},
        '{CH_0,   1'b0, 1'b0, 32'h0},
        '{CH_DOT, 1'b0, 1'b0, 32'h0},
        '{CH_NUL, 1'b1, 1'b0, 32'h0},
        '{CH_0,   1'b0, 1'b0, 32'h0},
        '{CH_9,   1'b0, 1'b0, 32'h0},
        '{CH_SPACE, 1'b0, 1'b0, 32'h0},
        '{8'hff,  1'b0, 1'b0, 32'h0},
        '{CH_NUL, 1'b0, 1'b0, 32'h0},
        '{CH_0,   1'b0, 1'b0, 32'h0},
        '{CH_X_LO, 1'b0, 1'b0, 32'h0},
        '{"A",    1'b0, 1'b0, 32'h0},
        '{"f",    1'b0, 1'b0, 32'h0},
        '{8'h80,  1'b0, 1'b0, 32'h0},
        '{CH_NUL, 1'b1, 1'b0, 32'h0}
    };

    ipv4_dotted_text_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_ch        (i_ch),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ok        (o_ok),
        .o_address   (o_address)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [4:0] hex_letter_val(logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
        return 5'd16;
    endfunction

    task automatic end_of_number(input logic [7:0] c);
        if (c == CH_DOT) begin
            if (pp_parts == 2'd3) begin
                pp_phase = PH_FAIL;
            end else begin
                pp_saved[pp_parts] = pp_value;
                pp_parts = pp_parts + 2'd1;
                pp_value = '0;
                pp_radix = RADIX_DEC;
                pp_phase = PH_START;
            end
        end else if (is_blank(c)) begin
            pp_phase = PH_TRAIL;
        end else begin
            pp_phase = PH_FAIL;
        end
    endtask

    task automatic take_digit(input logic [7:0] c);
        logic [31:0] base;
        logic [4:0]  h;
        base = (pp_radix == RADIX_HEX) ? 32'd16 : (pp_radix == RADIX_OCT) ? 32'd8 : 32'd10;
        h = hex_letter_val(c);
        if (is_digit(c))
            pp_value = pp_value * base + 32'(c - CH_0);
        else if (pp_radix == RADIX_HEX && h < 5'd16)
            pp_value = {pp_value[27:0], h[3:0]};
        else
            end_of_number(c);
    endtask

    task automatic parse_char(input logic [7:0] c, output bit done, output addr_result_t res);
        logic [31:0] v;
        done = 0;
        res = '0;
        if (c == CH_NUL) begin
            done = 1;
            v = pp_value;
            res.ok = pp_phase inside {PH_ZERO, PH_DIGITS, PH_TRAIL};
            case (pp_parts)
                2'd1: begin
                    if (v > LIMIT_1PART) res.ok = 0;
                    v = v | (pp_saved[0] << 24);
                end
                2'd2: begin
                    if (v > LIMIT_2PART) res.ok = 0;
                    v = v | (pp_saved[0] << 24) | (pp_saved[1] << 16);
                end
                2'd3: begin
                    if (v > LIMIT_3PART) res.ok = 0;
                    v = v | (pp_saved[0] << 24) | (pp_saved[1] << 16) | (pp_saved[2] << 8);
                end
                default: ;
            endcase
            if (res.ok) res.addr = v;
            pp_phase = PH_START;
            pp_radix = RADIX_DEC;
            pp_value = '0;
            pp_parts = '0;
        end else begin
            case (pp_phase)
                PH_START: begin
                    if (!is_digit(c)) begin
                        pp_phase = PH_FAIL;
                    end else if (c == CH_0) begin
                        pp_value = '0;
                        pp_phase = PH_ZERO;
                    end else begin
                        pp_radix = RADIX_DEC;
                        pp_value = 32'(c - CH_0);
                        pp_phase = PH_DIGITS;
                    end
                end
                PH_ZERO: begin
                    pp_phase = PH_DIGITS;
                    if (c == CH_X_LO || c == CH_X_UP) begin
                        pp_radix = RADIX_HEX;
                    end else begin
                        pp_radix = RADIX_OCT;
                        take_digit(c);
                    end
                end
                PH_DIGITS: take_digit(c);
                PH_TRAIL: ;
                default: pp_phase = PH_FAIL;
            endcase
        end
    endtask

    task automatic send_byte(input logic [7:0] b, output bit done, output addr_result_t res);
        int gap;
        if (!calm && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_cnt++;
        parse_char(b, done, res);
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++) text_q.push_back(t[i]);
    endtask

    function automatic logic [7:0] blank_byte();
        int unsigned sel;
        sel = $urandom_range(0, 5);
        return (sel == 5) ? CH_SPACE : 8'(CH_TAB + sel);
    endfunction

    function automatic logic [31:0] pick_part(bit last, int unsigned nparts);
        logic [31:0] lim;
        logic [31:0] r;
        lim = 32'hffff_ffff >> (8 * (nparts - 1));
        r = $urandom;
        if (!last) return ($urandom_range(0, 5) == 0) ? r : (r & 32'hff);
        case ($urandom_range(0, 9))
            0: return lim;
            1: return 32'h0;
            2: return (lim == 32'hffff_ffff) ? r : lim + 32'h1 + (r & 32'hff);
            default: return r & lim;
        endcase
    endfunction

    function automatic string number_text(logic [31:0] v);
        string h;
        string pfx;
        pfx = $urandom_range(0, 1) ? "0x" : "0X";
        h = $sformatf("%0h", v);
        case ($urandom_range(0, 3))
            0: return $sformatf("%0d", v);
            1: return (v == 0) ? "0" : $sformatf("0%0o", v);
            default: begin
                if (v == 0 && $urandom_range(0, 2) == 0) return pfx;
                return {pfx, $urandom_range(0, 1) ? h : h.toupper()};
            end
        endcase
    endfunction

    // one NUL-terminated string per call: mostly well formed, some damaged,
    // some long digit runs that wrap, some noise
    task automatic make_address_text();
        int unsigned kind;
        int unsigned nparts;
        int unsigned sel;
        int unsigned len;
        int unsigned r;
        int unsigned pos;
        string s;
        s = "";
        kind = $urandom_range(0, 99);
        if (kind < 88) begin
            nparts = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
            for (int p = 0; p < nparts; p++) begin
                if (p != 0) s = {s, "."};
                s = {s, number_text(pick_part(p == nparts - 1, nparts))};
            end
            if (kind >= 75) begin
                pos = $urandom_range(0, s.len() - 1);
                s.putc(pos, 8'($urandom_range(1, 255)));
            end
            put_text(s);
            sel = $urandom_range(0, 11);
            if (sel < 2) begin
                text_q.push_back(blank_byte());
                len = $urandom_range(0, 3);
                repeat (len) text_q.push_back(8'($urandom_range(1, 255)));
            end else if (sel == 2) begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end
        end else if (kind < 95) begin
            nparts = $urandom_range(1, 4);
            for (int p = 0; p < nparts; p++) begin
                if (p != 0) text_q.push_back(CH_DOT);
                sel = $urandom_range(0, 2);
                if (sel == 1) text_q.push_back(CH_0);
                if (sel == 2) put_text("0x");
                len = $urandom_range(1, 14);
                for (int d = 0; d < len; d++) begin
                    r = $urandom_range(0, (sel == 2) ? 21 : 9);
                    text_q.push_back(r < 10 ? 8'(8'h30 + r) :
                                     r < 16 ? 8'(8'h57 + r) : 8'(8'h31 + r));
                end
            end
        end else begin
            len = $urandom_range(0, 8);
            repeat (len) text_q.push_back(8'($urandom_range(1, 255)));
        end
        text_q.push_back(CH_NUL);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_addr_q.size() == 0) begin
                $error("unexpected result: ok=%0b address=%h", o_ok, o_address);
                fail_cnt++;
            end else begin
                got_want = pending_addr_q.pop_front();
                if (o_ok !== got_want.ok) begin
                    $error("ok: expected %0b, got %0b", got_want.ok, o_ok);
                    fail_cnt++;
                end
                if (o_address !== got_want.addr) begin
                    $error("address: expected %h, got %h", got_want.addr, o_address);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 0;
                hold_left = RX_HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 12);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : main
        bit           done;
        addr_result_t res;
        int           str_idx;
        int           waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < 26; r++) begin
            send_byte(dir_rows[r].ch, done, res);
            if (dir_rows[r].typed) begin
                res.ok   = dir_rows[r].ok;
                res.addr = dir_rows[r].addr;
            end
            if (done) pending_addr_q.push_back(res);
        end

        str_idx = 0;
        while (sent_cnt < RANDOM_BYTES) begin
            if (str_idx == 40) rx_hold_req = 1;
            calm = (str_idx >= 60 && str_idx < 75);
            if (str_idx == 50) begin
                i_in_valid <= 1'b0;
                while (pending_addr_q.size() != 0) @(posedge i_clk);
            end
            make_address_text();
            while (text_q.size() != 0) begin
                send_byte(text_q.pop_front(), done, res);
                if (done) pending_addr_q.push_back(res);
            end
            str_idx++;
        end
        i_in_valid <= 1'b0;
        calm = 0;

        waited = 0;
        while (pending_addr_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_addr_q.size() != 0) begin
            $error("%0d results never arrived", pending_addr_q.size());
            fail_cnt++;
        end

        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
